>>> sv/exyz_pkg.sv
// Shared constants, types and arithmetic helpers for the Euler XYZ rotation matrix block.
`timescale 1ns / 1ps

package exyz_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int ENTRY_BITS = 16;

  localparam int CORDIC_STEPS    = 32;
  localparam int FRAC            = 30;
  localparam int CORDIC_GAIN_INV = 652032874;
  localparam int A_SHIFT         = 32 - ANGLE_BITS;

  // CORDIC datapath width, trig value width, entry accumulation width
  localparam int ZW    = 34;
  localparam int SCW   = 32;
  localparam int SUM_W = 34;

  localparam int LANE_LAT = CORDIC_STEPS + 2;
  localparam int PIPE_LAT = LANE_LAT + 2;

  localparam int ENT_FRAC = ENTRY_BITS - 2;
  localparam int ENT_SH   = FRAC - ENT_FRAC;
  localparam int ENT_RND  = (1 << ENT_SH) >> 1;
  localparam int ENT_ONE  = 1 << ENT_FRAC;

  localparam int ATAN_TAB [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  typedef struct packed {
    logic signed [SCW-1:0] sn;
    logic signed [SCW-1:0] cs;
  } sc_t;

  typedef struct packed {
    logic signed [ENTRY_BITS-1:0] r00;
    logic signed [ENTRY_BITS-1:0] r01;
    logic signed [ENTRY_BITS-1:0] r02;
    logic signed [ENTRY_BITS-1:0] r10;
    logic signed [ENTRY_BITS-1:0] r11;
    logic signed [ENTRY_BITS-1:0] r12;
    logic signed [ENTRY_BITS-1:0] r20;
    logic signed [ENTRY_BITS-1:0] r21;
    logic signed [ENTRY_BITS-1:0] r22;
  } mat_t;

  function automatic logic signed [SCW-1:0] qmul(input logic signed [SCW-1:0] a,
                                                 input logic signed [SCW-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + (64'sd1 <<< (FRAC - 1));
    return SCW'(p >>> FRAC);
  endfunction

  function automatic logic signed [ENTRY_BITS-1:0] to_entry(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + SUM_W'(ENT_RND)) >>> ENT_SH;
    if (r > SUM_W'(ENT_ONE)) begin
      r = SUM_W'(ENT_ONE);
    end
    if (r < -SUM_W'(ENT_ONE)) begin
      r = -SUM_W'(ENT_ONE);
    end
    return ENTRY_BITS'(r);
  endfunction

endpackage

>>> sv/exyz_sincos.sv
// Pipelined CORDIC lane: sine and cosine of one binary angle.
`timescale 1ns / 1ps

module exyz_sincos import exyz_pkg::*; (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output sc_t                          sc
);

  logic [31:0]           a;
  logic                  flip;
  logic [31:0]           a_adj;
  logic signed [ZW-1:0]  x_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0]  y_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0]  z_r [CORDIC_STEPS+1];
  logic                  flip_r [CORDIC_STEPS+1];
  logic signed [SCW-1:0] sn_r;
  logic signed [SCW-1:0] cs_r;

  // fold the angle into plus or minus a quarter turn
  always_comb begin
    a     = 32'(angle) << A_SHIFT;
    flip  = a[31] ^ a[30];
    a_adj = {a[31] ^ flip, a[30:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= ZW'(CORDIC_GAIN_INV);
      y_r[0]    <= '0;
      z_r[0]    <= ZW'(signed'(a_adj));
      flip_r[0] <= flip;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ZW'(ATAN_TAB[i]);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ZW'(ATAN_TAB[i]);
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  // undo the half-turn fold
  always_ff @(posedge clk) begin
    if (en) begin
      if (flip_r[CORDIC_STEPS]) begin
        sn_r <= SCW'(-y_r[CORDIC_STEPS]);
        cs_r <= SCW'(-x_r[CORDIC_STEPS]);
      end else begin
        sn_r <= SCW'(y_r[CORDIC_STEPS]);
        cs_r <= SCW'(x_r[CORDIC_STEPS]);
      end
    end
  end

  assign sc.sn = sn_r;
  assign sc.cs = cs_r;

endmodule

>>> sv/exyz_merge.sv
// Merge stage: products of the lane results, sums, rounding and saturation.
`timescale 1ns / 1ps

module exyz_merge import exyz_pkg::*; (
  input  logic clk,
  input  logic en,
  input  sc_t  sc_x,
  input  sc_t  sc_y,
  input  sc_t  sc_z,
  output mat_t mat
);

  logic signed [SCW-1:0] cycz_r, cysz_r, cxsz_r, cxcz_r, sxsz_r;
  logic signed [SCW-1:0] sxcz_r, sxcy_r, cxcy_r, sxsy_r, cxsy_r;
  logic signed [SCW-1:0] sy1_r, cz1_r, sz1_r;

  logic signed [SCW-1:0] cycz2_r, cysz2_r, cxsz2_r, cxcz2_r, sxsz2_r;
  logic signed [SCW-1:0] sxcz2_r, sxcy2_r, cxcy2_r, sy2_r;
  logic signed [SCW-1:0] sxsycz_r, sxsysz_r, cxsycz_r, cxsysz_r;

  mat_t mat_r;
  mat_t mat_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      cycz_r <= qmul(sc_y.cs, sc_z.cs);
      cysz_r <= qmul(sc_y.cs, sc_z.sn);
      cxsz_r <= qmul(sc_x.cs, sc_z.sn);
      cxcz_r <= qmul(sc_x.cs, sc_z.cs);
      sxsz_r <= qmul(sc_x.sn, sc_z.sn);
      sxcz_r <= qmul(sc_x.sn, sc_z.cs);
      sxcy_r <= qmul(sc_x.sn, sc_y.cs);
      cxcy_r <= qmul(sc_x.cs, sc_y.cs);
      sxsy_r <= qmul(sc_x.sn, sc_y.sn);
      cxsy_r <= qmul(sc_x.cs, sc_y.sn);
      sy1_r  <= sc_y.sn;
      cz1_r  <= sc_z.cs;
      sz1_r  <= sc_z.sn;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cycz2_r  <= cycz_r;
      cysz2_r  <= cysz_r;
      cxsz2_r  <= cxsz_r;
      cxcz2_r  <= cxcz_r;
      sxsz2_r  <= sxsz_r;
      sxcz2_r  <= sxcz_r;
      sxcy2_r  <= sxcy_r;
      cxcy2_r  <= cxcy_r;
      sy2_r    <= sy1_r;
      sxsycz_r <= qmul(sxsy_r, cz1_r);
      sxsysz_r <= qmul(sxsy_r, sz1_r);
      cxsycz_r <= qmul(cxsy_r, cz1_r);
      cxsysz_r <= qmul(cxsy_r, sz1_r);
    end
  end

  always_comb begin
    mat_nxt.r00 = to_entry(SUM_W'(cycz2_r));
    mat_nxt.r01 = to_entry(-SUM_W'(cysz2_r));
    mat_nxt.r02 = to_entry(SUM_W'(sy2_r));
    mat_nxt.r10 = to_entry(SUM_W'(cxsz2_r) + SUM_W'(sxsycz_r));
    mat_nxt.r11 = to_entry(SUM_W'(cxcz2_r) - SUM_W'(sxsysz_r));
    mat_nxt.r12 = to_entry(-SUM_W'(sxcy2_r));
    mat_nxt.r20 = to_entry(SUM_W'(sxsz2_r) - SUM_W'(cxsycz_r));
    mat_nxt.r21 = to_entry(SUM_W'(sxcz2_r) + SUM_W'(cxsysz_r));
    mat_nxt.r22 = to_entry(SUM_W'(cxcy2_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat_r <= mat_nxt;
    end
  end

  assign mat = mat_r;

endmodule

>>> sv/euler_xyz_rotation_matrix.sv
// Top level: Euler XYZ angles to 3x3 rotation matrix, three CORDIC lanes and a merge stage.
// Each transfer passes through the registered CORDIC lanes and then the registered merge stage.
// Throughput: one transfer per cycle while the output is not stalled; the 32-stage CORDIC lanes are fully pipelined.
// A stalled output holds the whole pipeline; in_ready follows out_ready while output is full.
// Reset clears the valid pipeline and out_valid; the datapath is not reset.
`timescale 1ns / 1ps

module euler_xyz_rotation_matrix import exyz_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ANGLE_BITS-1:0] in_angle_x,
  input  logic signed [ANGLE_BITS-1:0] in_angle_y,
  input  logic signed [ANGLE_BITS-1:0] in_angle_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ENTRY_BITS-1:0] out_r00,
  output logic signed [ENTRY_BITS-1:0] out_r01,
  output logic signed [ENTRY_BITS-1:0] out_r02,
  output logic signed [ENTRY_BITS-1:0] out_r10,
  output logic signed [ENTRY_BITS-1:0] out_r11,
  output logic signed [ENTRY_BITS-1:0] out_r12,
  output logic signed [ENTRY_BITS-1:0] out_r20,
  output logic signed [ENTRY_BITS-1:0] out_r21,
  output logic signed [ENTRY_BITS-1:0] out_r22
);

  logic                adv;
  logic [PIPE_LAT-1:0] vld_r;
  logic                out_valid_r;
  sc_t                 sc_x;
  sc_t                 sc_y;
  sc_t                 sc_z;
  mat_t                mat;

  // advance unless a finished result is waiting and not taken
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE_LAT-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  exyz_sincos u_lane_x (
    .clk   (clk),
    .en    (adv),
    .angle (in_angle_x),
    .sc    (sc_x)
  );

  exyz_sincos u_lane_y (
    .clk   (clk),
    .en    (adv),
    .angle (in_angle_y),
    .sc    (sc_y)
  );

  exyz_sincos u_lane_z (
    .clk   (clk),
    .en    (adv),
    .angle (in_angle_z),
    .sc    (sc_z)
  );

  exyz_merge u_merge (
    .clk  (clk),
    .en   (adv),
    .sc_x (sc_x),
    .sc_y (sc_y),
    .sc_z (sc_z),
    .mat  (mat)
  );

  assign out_valid = out_valid_r;
  assign out_r00   = mat.r00;
  assign out_r01   = mat.r01;
  assign out_r02   = mat.r02;
  assign out_r10   = mat.r10;
  assign out_r11   = mat.r11;
  assign out_r12   = mat.r12;
  assign out_r20   = mat.r20;
  assign out_r21   = mat.r21;
  assign out_r22   = mat.r22;

endmodule
